// ----- sv/lprp_pkg.sv -----
// shared types and constants for the lru page replacement unit
package lprp_pkg;

	localparam int PAGE_IN_W  = 16;
	localparam int CFG_W      = 4;
	localparam int FUSED_W    = 3;
	localparam int MISS_W     = 32;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 40;
	localparam int M_PAD_W    = M_TDATA_W - FUSED_W - MISS_W;
	localparam int CNT_W      = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} lprp_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic update;
	} lprp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} lprp_status_t;

endpackage

// ----- sv/lprp_ctrl.sv -----
// control state machine: accept, frame scan, table update
module lprp_ctrl
	import lprp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  lprp_status_t status,
	output lprp_cmd_t    cmd
);

	lprp_state_t state_q;
	lprp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.update = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- sv/lprp_datapath.sv -----
// frame table, page memory, age counters, miss counter and result register
module lprp_datapath
	import lprp_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16,
	parameter int AGE_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lprp_cmd_t            cmd,
	output lprp_status_t         status,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [PAGE_IN_W-1:0] in_page,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_hit,
	output logic [FUSED_W-1:0]   out_frame,
	output logic [MISS_W-1:0]    out_miss
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(FRAMES - 1);

	logic [PAGE_BITS-1:0] page_mem [FRAMES];
	logic [PAGE_BITS-1:0] rdata_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic [IDX_W-1:0]     rd_addr_q;

	logic [FRAMES-1:0]    valid_q;
	logic [AGE_BITS-1:0]  age_q [FRAMES];

	logic [CFG_W-1:0]     frames_q;
	logic [PAGE_BITS-1:0] pg_q;
	logic                 last_q;
	logic [IDX_W-1:0]     pick_q;
	logic [AGE_BITS-1:0]  best_q;
	logic                 hit_q;
	logic [MISS_W-1:0]    miss_q;

	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [MISS_W-1:0]    out_miss_q;

	logic [PAGE_BITS+PAGE_IN_W-1:0] page_ext;
	logic [CNT_W-1:0]     cfg_ext;
	logic [CNT_W-1:0]     active_cnt;
	logic [IDX_W-1:0]     last_idx;
	logic                 cur_valid;
	logic                 cur_hit;
	logic                 cur_empty;
	logic [AGE_BITS-1:0]  cur_age;
	logic [MISS_W-1:0]    miss_next;
	logic                 out_free;
	logic [IDX_W+FUSED_W-1:0] idx_ext;

	// page field taken modulo 2^PAGE_BITS, zero extended if wider
	assign page_ext = {{PAGE_BITS{1'b0}}, in_page};

	// clamp frame count into 1..FRAMES
	assign cfg_ext = CNT_W'(frames_q);
	always_comb begin
		priority if (cfg_ext == '0) begin
			active_cnt = CNT_W'(1);
		end else if (cfg_ext > CNT_W'(FRAMES)) begin
			active_cnt = CNT_W'(FRAMES);
		end else begin
			active_cnt = cfg_ext;
		end
	end
	assign last_idx = IDX_W'(active_cnt - CNT_W'(1));

	assign cur_valid = valid_q[cmp_idx_s1];
	assign cur_age   = age_q[cmp_idx_s1];
	assign cur_hit   = cur_valid && (rdata_s1 == pg_q);
	assign cur_empty = !cur_valid;

	assign status.scan_done = cur_hit || cur_empty || (cmp_idx_s1 == last_idx);
	assign out_free         = !out_valid_q || out_ready;
	assign status.out_free  = out_free;

	assign miss_next = hit_q ? miss_q :
		((miss_q == '1) ? miss_q : miss_q + MISS_W'(1));

	// page memory, one read port scanned one frame a cycle
	always_ff @(posedge clk) begin
		if (cmd.update && !hit_q) begin
			page_mem[pick_q] <= pg_q;
		end
		rdata_s1   <= page_mem[rd_addr_q];
		cmp_idx_s1 <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
		end else if (cmd.update) begin
			rd_addr_q <= '0;
		end else if ((cmd.start || cmd.scan) && (rd_addr_q != LAST_ADDR)) begin
			rd_addr_q <= rd_addr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	// reference word and scan result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pg_q   <= page_ext[PAGE_BITS-1:0];
			last_q <= in_last;
			pick_q <= '0;
			best_q <= '0;
			hit_q  <= 1'b0;
		end else if (cmd.scan) begin
			priority if (cur_hit) begin
				pick_q <= cmp_idx_s1;
				hit_q  <= 1'b1;
			end else if (cur_empty) begin
				pick_q <= cmp_idx_s1;
			end else if (cur_age > best_q) begin
				pick_q <= cmp_idx_s1;
				best_q <= cur_age;
			end
		end
	end

	// table state update, cleared after a last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			miss_q  <= '0;
			for (int j = 0; j < FRAMES; j++) begin
				age_q[j] <= '0;
			end
		end else if (cmd.update) begin
			if (last_q) begin
				valid_q <= '0;
				miss_q  <= '0;
				for (int j = 0; j < FRAMES; j++) begin
					age_q[j] <= '0;
				end
			end else begin
				miss_q <= miss_next;
				if (!hit_q) begin
					valid_q[pick_q] <= 1'b1;
				end
				for (int j = 0; j < FRAMES; j++) begin
					if (IDX_W'(j) == pick_q) begin
						age_q[j] <= '0;
					end else if (age_q[j] != '1) begin
						age_q[j] <= age_q[j] + AGE_BITS'(1);
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_hit_q  <= hit_q;
			out_idx_q  <= pick_q;
			out_miss_q <= miss_next;
		end
	end

	assign idx_ext   = {{FUSED_W{1'b0}}, out_idx_q};
	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_frame = idx_ext[FUSED_W-1:0];
	assign out_miss  = out_miss_q;

endmodule

// ----- sv/lru_page_replacement_unit.sv -----
// lru page replacement unit: fully associative page frame table, top level
// a new reference is taken only in idle, once the last one has updated the table
// the scan is paced by the single read port of the page memory, which it walks one frame
// per cycle until a hit, an empty frame or the last active frame
// reset: frames empty, ages and miss count zero, frames_in_use = 8, no result pending
// the page memory itself is not cleared, valid bits guard every read
module lru_page_replacement_unit
	import lprp_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16,
	parameter int AGE_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: frames_in_use
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// reference words in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] page
	input  logic                 s_tlast,   // last_access
	// result words out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] frame_used, [34:3] miss_total, rest zero
	output logic                 m_tuser    // hit
);

	lprp_cmd_t    cmd;
	lprp_status_t status;

	logic [FUSED_W-1:0] frame_used;
	logic [MISS_W-1:0]  miss_total;

	// sequencer: idle -> scan frames -> update table and load result register
	lprp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// frame table, ages, miss count and output register
	lprp_datapath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.AGE_BITS  (AGE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_page   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hit   (m_tuser),
		.out_frame (frame_used),
		.out_miss  (miss_total)
	);

	// result word packing, frame index in the low bits
	assign m_tdata = {{M_PAD_W{1'b0}}, miss_total, frame_used};

endmodule
